// ===== src/wsd_pkg.sv =====
package wsd_pkg;

   // Width of the payload length counter; longer lengths saturate
   localparam int LENGTH_BITS = 64;

   // Result queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Frame opcodes
   localparam logic [3:0] OP_CONT  = 4'd0;
   localparam logic [3:0] OP_TEXT  = 4'd1;
   localparam logic [3:0] OP_BIN   = 4'd2;
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING  = 4'd9;
   localparam logic [3:0] OP_PONG  = 4'd10;

   // Seven-bit length codes that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Extended length bytes still to come after the first one
   localparam logic [2:0] EXT16_LEFT = 3'd1;
   localparam logic [2:0] EXT64_LEFT = 3'd7;

   // Last mask key byte position
   localparam logic [1:0] KEY_LAST = 2'd3;

   // Message types
   localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
   localparam logic [1:0] TYPE_TEXT    = 2'd1;
   localparam logic [1:0] TYPE_BINARY  = 2'd2;

   typedef enum logic [1:0] {
      EV_DATA    = 2'd0,
      EV_DISCARD = 2'd1,
      EV_CLOSE   = 2'd2,
      EV_HALT    = 2'd3
   } event_type;

   // One queued result: raw byte and key byte are combined in the back end
   typedef struct packed {
      event_type  ev;
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [1:0] msg_type;
      logic       msg_end;
   } entry_type;

endpackage

// ===== src/wsd_parser.sv =====
module wsd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output logic               push,
   output wsd_pkg::entry_type push_entry
);

   typedef enum logic [6:0] {
      PH_HDR0   = 7'b0000001,
      PH_HDR1   = 7'b0000010,
      PH_EXTLEN = 7'b0000100,
      PH_KEY    = 7'b0001000,
      PH_DATA   = 7'b0010000,
      PH_HALT   = 7'b0100000,
      PH_CLOSED = 7'b1000000
   } phase_type;

   localparam int LB = wsd_pkg::LENGTH_BITS;

   phase_type       phase_ff, phase_in;
   logic            final_ff, final_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            masked_ff, masked_in;
   logic [3:0]      opening_ff, opening_in;
   logic [2:0]      len_left_ff, len_left_in;
   logic [LB-1:0]   remain_ff, remain_in;
   logic [31:0]     key_ff, key_in;
   logic [1:0]      index_ff, index_in;

   logic            hdr_done;
   logic [6:0]      len7;
   logic [LB-1:0]   remain_dec;
   logic            last;
   logic [7:0]      key_byte;
   logic [3:0]      type_op;
   logic [1:0]      cur_type;

   // Current key byte, most significant byte first
   assign key_byte   = masked_ff ? key_ff[{~index_ff, 3'b000} +: 8] : 8'd0;
   assign remain_dec = remain_ff - {{(LB-1){1'b0}}, 1'b1};
   assign last       = (remain_dec == '0);
   assign len7       = rx_byte[6:0];

   // Map the effective opcode to a message type
   always_comb begin
      type_op = (opcode_ff == wsd_pkg::OP_CONT) ? opening_ff : opcode_ff;
      case (type_op)
         wsd_pkg::OP_TEXT: cur_type = wsd_pkg::TYPE_TEXT;
         wsd_pkg::OP_BIN:  cur_type = wsd_pkg::TYPE_BINARY;
         default:          cur_type = wsd_pkg::TYPE_UNKNOWN;
      endcase
   end

   // Advance the frame state by one byte
   always_comb begin
      phase_in    = phase_ff;
      final_in    = final_ff;
      opcode_in   = opcode_ff;
      masked_in   = masked_ff;
      opening_in  = opening_ff;
      len_left_in = len_left_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      index_in    = index_ff;
      hdr_done    = 1'b0;
      push        = 1'b0;
      push_entry  = '0;

      if (accept) begin
         case (phase_ff)
            PH_HALT, PH_CLOSED: begin
               // drop everything until reset
            end
            PH_HDR1: begin
               masked_in = rx_byte[7];
               key_in    = '0;
               index_in  = '0;
               remain_in = '0;
               if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
                  len_left_in = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_LEFT
                                                             : wsd_pkg::EXT64_LEFT;
                  phase_in    = PH_EXTLEN;
               end else begin
                  remain_in = {{(LB-7){1'b0}}, len7};
                  if (rx_byte[7]) begin
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               // Shift in one length byte, saturating at the counter range
               if (remain_ff[LB-1 -: 8] != 8'd0) begin
                  remain_in = '1;
               end else begin
                  remain_in = {remain_ff[LB-9:0], rx_byte};
               end
               if (len_left_ff != 3'd0) begin
                  len_left_in = len_left_ff - 3'd1;
               end else if (masked_ff) begin
                  phase_in = PH_KEY;
               end else begin
                  hdr_done = 1'b1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               if (index_ff != wsd_pkg::KEY_LAST) begin
                  index_in = index_ff + 2'd1;
               end else begin
                  index_in = '0;
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               index_in  = index_ff + 2'd1;
               remain_in = remain_dec;
               if (opcode_ff == wsd_pkg::OP_CLOSE) begin
                  if (last) begin
                     phase_in      = PH_CLOSED;
                     push          = 1'b1;
                     push_entry.ev = wsd_pkg::EV_CLOSE;
                  end
               end else begin
                  push                = 1'b1;
                  push_entry.ev       = wsd_pkg::EV_DATA;
                  push_entry.raw_byte = rx_byte;
                  push_entry.key_byte = key_byte;
                  push_entry.msg_type = cur_type;
                  push_entry.msg_end  = last & final_ff;
                  if (last) begin
                     phase_in = PH_HDR0;
                     if (final_ff) begin
                        opening_in = wsd_pkg::OP_CONT;
                     end
                  end
               end
            end
            default: begin
               // First header byte
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
               if (rx_byte[3:0] == wsd_pkg::OP_PING || rx_byte[3:0] == wsd_pkg::OP_PONG) begin
                  phase_in      = PH_HALT;
                  push          = 1'b1;
                  push_entry.ev = wsd_pkg::EV_HALT;
               end else begin
                  if (!rx_byte[7] && rx_byte[3:0] != wsd_pkg::OP_CONT
                      && rx_byte[3:0] != wsd_pkg::OP_CLOSE) begin
                     opening_in = rx_byte[3:0];
                  end
                  phase_in = PH_HDR1;
               end
            end
         endcase

         // Header complete: enter payload or close out an empty frame
         if (hdr_done) begin
            if (remain_in != '0) begin
               phase_in = PH_DATA;
            end else if (opcode_ff == wsd_pkg::OP_CLOSE) begin
               phase_in      = PH_CLOSED;
               push          = 1'b1;
               push_entry.ev = wsd_pkg::EV_CLOSE;
            end else begin
               phase_in = PH_HDR0;
               if (final_ff) begin
                  opening_in    = wsd_pkg::OP_CONT;
                  push          = 1'b1;
                  push_entry.ev = wsd_pkg::EV_DISCARD;
               end
            end
         end
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         final_ff    <= 1'b0;
         opcode_ff   <= '0;
         masked_ff   <= 1'b0;
         opening_ff  <= '0;
         len_left_ff <= '0;
         remain_ff   <= '0;
         key_ff      <= '0;
         index_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         final_ff    <= final_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         opening_ff  <= opening_in;
         len_left_ff <= len_left_in;
         remain_ff   <= remain_in;
         key_ff      <= key_in;
         index_ff    <= index_in;
      end
   end

endmodule

// ===== src/wsd_queue.sv =====
module wsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsd_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output wsd_pkg::entry_type head
);

   localparam int PB = wsd_pkg::QUEUE_PTR_BITS;
   localparam int CB = wsd_pkg::QUEUE_CNT_BITS;

   wsd_pkg::entry_type store_ff [wsd_pkg::QUEUE_DEPTH];
   logic [PB-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CB'(wsd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(wsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(wsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/wsd_emit.sv =====
module wsd_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  wsd_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_res,
   output logic [7:0]         rsp_data_byte,
   output logic [1:0]         rsp_message_type,
   output logic               rsp_message_end
);

   logic       valid_ff;
   logic [1:0] event_ff;
   logic [7:0] data_ff;
   logic [1:0] type_ff;
   logic       end_ff;
   logic       load;

   // Take the next item whenever the output register is free or drains
   assign load = ~valid_ff | ~rsp_stall;
   assign pop  = load & head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
      end
   end

   // Unmask payload into the output register
   always_ff @(posedge clock) begin
      if (pop) begin
         event_ff <= head.ev;
         data_ff  <= head.raw_byte ^ head.key_byte;
         type_ff  <= head.msg_type;
         end_ff   <= head.msg_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_message_type = type_ff;
   assign rsp_message_end  = end_ff;

endmodule

// ===== src/websocket_frame_deframer_top.sv =====
// WebSocket receive deframer: one frame stream byte is taken per cycle on the req_ channel
// and causes zero or one item on the rsp_ channel (a payload byte already unmasked, a
// discard of an empty final frame, a close report, or a halt on ping/pong). The parser
// keeps up at one byte per cycle; a four-item queue and the output register sit between
// it and the rsp_ side, so req_stall rises only once that queue is full. Each result
// passes the queue and then the output register. After close or ping/pong the block
// swallows all further bytes until reset. Lengths beyond the 64-bit counter saturate.
module websocket_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_message_type,
   output logic       rsp_message_end
);

   logic               accept;
   logic               push;
   wsd_pkg::entry_type push_entry;
   logic               full;
   logic               not_empty;
   logic               pop;
   wsd_pkg::entry_type head;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   wsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   wsd_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_message_type (rsp_message_type),
      .rsp_message_end  (rsp_message_end)
   );

endmodule

// ===== dv/websocket_frame_deframer_top_tb.sv =====
module websocket_frame_deframer_top_tb;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 5;
   localparam int STREAM_BYTES = 650;
   localparam int GAP_PERCENT = 12;
   localparam int CALM_FROM = 350;
   localparam int CALM_TO = 560;
   localparam int HOLD_AT = 120;
   localparam int HOLD_CYCLES = 48;
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT = 1000;
   localparam int PRINT_LIMIT = 200;

   // Opcode outside every defined frame kind
   localparam logic [3:0] OP_RESERVED_HI = 4'hF;

   localparam logic [wsd_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;

   typedef enum logic [2:0] {
      ST_HEAD0, ST_HEAD1, ST_LENGTH, ST_KEY, ST_PAYLOAD, ST_HALTED, ST_CLOSED
   } parse_state_type;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

   typedef enum int {END_CLOSE, END_PING, END_PONG, END_ENDLESS} stream_end_type;

   typedef struct {
      wsd_pkg::event_type ev;
      logic [7:0]         data;
      logic [1:0]         kind;
      logic               last;
   } deframe_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_message_type;
   logic       rsp_message_end;

   logic [7:0]         stream_bytes[$];
   deframe_result_type awaited_events[$];
   logic [3:0]         data_ops[3] = '{wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN};

   // Deframer state as the byte stream is accepted
   parse_state_type                 st = ST_HEAD0;
   logic                            fin_seen = 1'b0;
   logic [3:0]                      cur_op = wsd_pkg::OP_CONT;
   logic                            masked = 1'b0;
   logic [3:0]                      msg_op = wsd_pkg::OP_CONT;
   logic [2:0]                      ext_left = '0;
   logic [wsd_pkg::LENGTH_BITS-1:0] bytes_left = '0;
   logic [31:0]                     key_word = '0;
   logic [1:0]                      key_pos = '0;

   int             errors = 0;
   int             bytes_sent = 0;
   int             results_seen = 0;
   int             frames_built = 0;
   int             quiet_cycles = 0;
   int             cycle_no = 0;
   int             hold_left = 0;
   stream_end_type finale;

   websocket_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_message_type (rsp_message_type),
      .rsp_message_end  (rsp_message_end)
   );

   initial forever #(HALF_PERIOD) clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      errors++;
   endtask

   function automatic void post_event(wsd_pkg::event_type ev, logic [7:0] data,
                                      logic [1:0] kind, logic last);
      deframe_result_type r;
      r.ev = ev;
      r.data = data;
      r.kind = kind;
      r.last = last;
      awaited_events.push_back(r);
   endfunction

   // Continuations inherit the type of the open message
   function automatic logic [1:0] payload_kind();
      logic [3:0] op;
      op = (cur_op == wsd_pkg::OP_CONT) ? msg_op : cur_op;
      if (op == wsd_pkg::OP_TEXT) return wsd_pkg::TYPE_TEXT;
      if (op == wsd_pkg::OP_BIN) return wsd_pkg::TYPE_BINARY;
      return wsd_pkg::TYPE_UNKNOWN;
   endfunction

   // Header complete: enter payload, or close out an empty frame
   function automatic void end_header();
      if (bytes_left != '0) begin
         st = ST_PAYLOAD;
      end else if (cur_op == wsd_pkg::OP_CLOSE) begin
         st = ST_CLOSED;
         post_event(wsd_pkg::EV_CLOSE, 8'h00, wsd_pkg::TYPE_UNKNOWN, 1'b0);
      end else begin
         st = ST_HEAD0;
         if (fin_seen) begin
            msg_op = wsd_pkg::OP_CONT;
            post_event(wsd_pkg::EV_DISCARD, 8'h00, wsd_pkg::TYPE_UNKNOWN, 1'b0);
         end
      end
   endfunction

   // Advance the deframer by one accepted byte and queue what it emits
   function automatic void deframe_byte(logic [7:0] b);
      logic [wsd_pkg::LENGTH_BITS+7:0] shifted;
      logic [7:0]                      key;
      logic                            last;
      case (st)
         ST_HALTED, ST_CLOSED: begin
            // drop every byte until reset
         end
         ST_HEAD1: begin
            masked = b[7];
            key_word = '0;
            key_pos = '0;
            bytes_left = '0;
            if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
               ext_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_LEFT
                                                         : wsd_pkg::EXT64_LEFT;
               st = ST_LENGTH;
            end else begin
               bytes_left = wsd_pkg::LENGTH_BITS'(b[6:0]);
               if (masked) st = ST_KEY;
               else end_header();
            end
         end
         ST_LENGTH: begin
            // shift in big-endian, saturate past the counter width
            shifted = {bytes_left, b};
            bytes_left = (shifted > {8'h00, LEN_MAX}) ? LEN_MAX
                                                      : shifted[wsd_pkg::LENGTH_BITS-1:0];
            if (ext_left != '0) ext_left = ext_left - 3'd1;
            else if (masked) st = ST_KEY;
            else end_header();
         end
         ST_KEY: begin
            key_word = {key_word[23:0], b};
            if (key_pos != wsd_pkg::KEY_LAST) begin
               key_pos = key_pos + 2'd1;
            end else begin
               key_pos = '0;
               end_header();
            end
         end
         ST_PAYLOAD: begin
            key = masked ? key_word[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
            key_pos = key_pos + 2'd1;
            bytes_left = bytes_left - 1'b1;
            last = (bytes_left == '0);
            if (cur_op == wsd_pkg::OP_CLOSE) begin
               // close payload is swallowed, close reported on its last byte
               if (last) begin
                  st = ST_CLOSED;
                  post_event(wsd_pkg::EV_CLOSE, 8'h00, wsd_pkg::TYPE_UNKNOWN, 1'b0);
               end
            end else begin
               post_event(wsd_pkg::EV_DATA, b ^ key, payload_kind(), last && fin_seen);
               if (last) begin
                  st = ST_HEAD0;
                  if (fin_seen) msg_op = wsd_pkg::OP_CONT;
               end
            end
         end
         default: begin
            fin_seen = b[7];
            cur_op = b[3:0];
            if (cur_op == wsd_pkg::OP_PING || cur_op == wsd_pkg::OP_PONG) begin
               st = ST_HALTED;
               post_event(wsd_pkg::EV_HALT, 8'h00, wsd_pkg::TYPE_UNKNOWN, 1'b0);
            end else begin
               // an opening fragment remembers its type
               if (!fin_seen && cur_op != wsd_pkg::OP_CONT && cur_op != wsd_pkg::OP_CLOSE)
                  msg_op = cur_op;
               st = ST_HEAD1;
            end
         end
      endcase
   endfunction

   function automatic void push_header(logic fin, logic [2:0] rsv, logic [3:0] op,
                                       logic with_key, logic [63:0] len,
                                       length_form_type form, logic [31:0] key);
      stream_bytes.push_back({fin, rsv, op});
      case (form)
         FORM_SHORT: stream_bytes.push_back({with_key, len[6:0]});
         FORM_EXT16: begin
            stream_bytes.push_back({with_key, wsd_pkg::LEN_EXT16});
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[7:0]);
         end
         default: begin
            stream_bytes.push_back({with_key, wsd_pkg::LEN_EXT64});
            for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
         end
      endcase
      if (with_key) begin
         for (int i = 3; i >= 0; i--) stream_bytes.push_back(key[8*i +: 8]);
      end
      frames_built++;
   endfunction

   function automatic void push_payload(int unsigned n);
      for (int unsigned i = 0; i < n; i++) stream_bytes.push_back(8'($urandom));
   endfunction

   // Random frame: mostly short payloads, now and then long or extended lengths
   function automatic void random_frame(logic fin, logic [3:0] op);
      int unsigned     pick;
      int unsigned     len;
      length_form_type form;
      pick = $urandom_range(99);
      form = FORM_SHORT;
      if (pick < 75) begin
         len = $urandom_range(10);
      end else if (pick < 85) begin
         len = $urandom_range(125, 11);
      end else if (pick < 95) begin
         len = $urandom_range(140);
         form = FORM_EXT16;
      end else begin
         len = $urandom_range(24);
         form = FORM_EXT64;
      end
      push_header(fin, 3'($urandom), op, 1'($urandom), 64'(len), form, $urandom);
      push_payload(len);
   endfunction

   function automatic bit gap_now();
      if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
      return $urandom_range(99) < GAP_PERCENT;
   endfunction

   // Count cycles and cycles without any handshake
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // Feed the byte stream; predict each byte as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() != 0 && !gap_now()) begin
               req_valid <= 1'b1;
               req_rx_byte <= stream_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result item against the oldest prediction; drive stall
   always @(posedge clock) begin : watch_rsp
      deframe_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_events.size() == 0) begin
            report_mismatch($sformatf("unexpected item ev %0d data %02h type %0d end %0d",
                                      rsp_event_res, rsp_data_byte, rsp_message_type,
                                      rsp_message_end));
         end else begin
            want = awaited_events.pop_front();
            if (rsp_event_res !== want.ev || rsp_data_byte !== want.data ||
                rsp_message_type !== want.kind || rsp_message_end !== want.last) begin
               report_mismatch({
                  $sformatf("item %0d got ev %0d data %02h type %0d end %0d,",
                            results_seen, rsp_event_res, rsp_data_byte,
                            rsp_message_type, rsp_message_end),
                  $sformatf(" want ev %0d data %02h type %0d end %0d",
                            want.ev, want.data, want.kind, want.last)});
            end
         end
      end
      // hold off once for a long stretch so the block backs up
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (cycle_no == HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= gap_now();
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("websocket_frame_deframer_top verification failed");
      $finish;
   end

   initial begin : run_stimulus
      int unsigned pick;
      int unsigned parts;
      int unsigned len;
      logic [3:0]  op;

      // directed: byte extremes, all-ones key, fragment over 16- and 64-bit lengths,
      // empty final frame with reserved bits and an undefined opcode
      push_header(1'b1, 3'b000, wsd_pkg::OP_TEXT, 1'b0, 64'd1, FORM_SHORT, 32'h0);
      stream_bytes.push_back(8'h00);
      push_header(1'b1, 3'b000, wsd_pkg::OP_BIN, 1'b1, 64'd2, FORM_SHORT, 32'hFFFF_FFFF);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h00);
      push_header(1'b0, 3'b000, wsd_pkg::OP_TEXT, 1'b0, 64'd1, FORM_EXT16, 32'h0);
      stream_bytes.push_back(8'h41);
      push_header(1'b1, 3'b000, wsd_pkg::OP_CONT, 1'b0, 64'd1, FORM_EXT64, 32'h0);
      stream_bytes.push_back(8'hFF);
      push_header(1'b1, 3'b111, OP_RESERVED_HI, 1'b0, 64'd0, FORM_SHORT, 32'h0);

      // random: mostly well-formed messages, plus empty, orphaned and odd frames
      while (stream_bytes.size() < STREAM_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            parts = $urandom_range(4, 1);
            op = $urandom_range(1) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BIN;
            for (int unsigned i = 0; i < parts; i++)
               random_frame(i == parts - 1, (i == 0) ? op : wsd_pkg::OP_CONT);
         end else if (pick < 72) begin
            push_header(1'b1, 3'($urandom), data_ops[$urandom_range(2)], 1'($urandom), 64'd0,
                        FORM_SHORT, $urandom);
         end else if (pick < 84) begin
            random_frame(1'($urandom), wsd_pkg::OP_CONT);
         end else begin
            do op = 4'($urandom);
            while (op == wsd_pkg::OP_CONT || op == wsd_pkg::OP_TEXT ||
                   op == wsd_pkg::OP_BIN || op == wsd_pkg::OP_CLOSE ||
                   op == wsd_pkg::OP_PING || op == wsd_pkg::OP_PONG);
            random_frame(1'($urandom), op);
         end
      end

      // the stream ends in close, ping, pong or a frame too long to finish
      finale = stream_end_type'($urandom_range(3));
      case (finale)
         END_CLOSE: begin
            len = $urandom_range(6);
            push_header(1'($urandom), 3'($urandom), wsd_pkg::OP_CLOSE, 1'($urandom),
                        64'(len), FORM_SHORT, $urandom);
            push_payload(len);
         end
         END_PING: stream_bytes.push_back({1'($urandom), 3'($urandom), wsd_pkg::OP_PING});
         END_PONG: stream_bytes.push_back({1'($urandom), 3'($urandom), wsd_pkg::OP_PONG});
         default: push_header(1'($urandom), 3'($urandom), wsd_pkg::OP_TEXT, 1'($urandom),
                              {1'b1, 63'({$urandom, $urandom})}, FORM_EXT64, $urandom);
      endcase
      // trailing bytes: swallowed after a halt, payload otherwise
      push_payload(8);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for the stream to drain, then for every predicted item
      while (stream_bytes.size() != 0 || req_valid) @(negedge clock);
      while (awaited_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d bytes in %0d frames and checked %0d result items,",
               bytes_sent, frames_built, results_seen);
      $display("with one long output hold-off; the stream ended with %s.", finale.name());
      if (errors == 0) begin
         $display("websocket_frame_deframer_top verification clean");
      end else begin
         $display("websocket_frame_deframer_top verification failed");
      end
      $finish;
   end

endmodule
